// File: src/ths_pkg.sv
// ths_pkg: shared types, field layout and arithmetic constants for the
// terrain height sampler. No dependencies.

package ths_pkg;

    // default build parameters
    localparam int DEF_MAX_SIDE  = 256;
    localparam int DEF_FRAC_BITS = 8;

    // field widths
    localparam int CELL_W   = 8;
    localparam int CHAN_W   = 8;
    localparam int POS_W    = 17;
    localparam int SUM_W    = 10;
    localparam int GRID_W   = 9;
    localparam int HEIGHT_W = 19;

    // input word layout, lowest bit first
    localparam int IN_TDATA_W  = 80;
    localparam int CELL_X_LSB  = 0;
    localparam int CELL_Z_LSB  = 8;
    localparam int RED_LSB     = 16;
    localparam int GREEN_LSB   = 24;
    localparam int BLUE_LSB    = 32;
    localparam int POS_X_LSB   = 40;
    localparam int POS_Z_LSB   = 57;
    localparam int OUT_TDATA_W = 24;

    // weights are at most 1.0 with up to 16 fraction bits
    localparam int WGT_W = 17;

    // height = floor(N' / 45) - 4096, N' < 2^18 for any fraction width
    localparam int                   NQ_W         = 18;
    localparam int                   DIV45_MULT_W = 19;
    localparam logic [DIV45_MULT_W-1:0] DIV45_MULT = 19'd372828; // ceil(2^24/45)
    localparam int                   DIV45_SHIFT  = 24;
    localparam int                   PROD_W       = NQ_W + DIV45_MULT_W;
    localparam int                   Q_W          = PROD_W - DIV45_SHIFT;

    localparam logic signed [HEIGHT_W-1:0] OFF_HEIGHT = -19'sd256000;
    localparam logic signed [HEIGHT_W-1:0] SHIFT_DOWN = 19'sd4096;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam int CFG_IDX_W = 1;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH = 1'b0,
        CFG_GRID_DEPTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ2,
        PH_READ3
    } t_phase;

    // one corner read: travels with the store read, lines up with its data
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             off;
        logic [WGT_W-1:0] weight;
    } t_mac_ctl;

endpackage

// File: src/ths_store.sv
// ths_store: single-port heightmap store of channel sums, with registered
// read data. Depends on ths_pkg.

module ths_store import ths_pkg::*; #(
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [SUM_W-1:0]  i_wdata,
    output logic [SUM_W-1:0]  o_rdata
);

    logic [SUM_W-1:0] mem [2**ADDR_W];
    logic [SUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ths_seq.sv
// ths_seq: input decode and store sequencer. Writes loads, issues the three
// corner reads of a query with their weights. Depends on ths_pkg.

module ths_seq import ths_pkg::*; #(
    parameter int MAX_SIDE  = DEF_MAX_SIDE,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int ADDR_W    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_data,
    input  logic                  i_user,
    input  logic                  i_room,
    input  logic [GRID_W-1:0]     i_grid_width,
    input  logic [GRID_W-1:0]     i_grid_depth,
    output logic                  o_reserve,
    output logic                  o_mem_en,
    output logic                  o_mem_we,
    output logic [ADDR_W-1:0]     o_mem_addr,
    output logic [SUM_W-1:0]      o_mem_wdata,
    output t_mac_ctl              o_mac
);

    localparam int                SB       = ADDR_W / 2;
    localparam logic [FRAC_BITS:0] ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [POS_W-1:0]  SIDE_LIM = POS_W'(MAX_SIDE);

    t_phase r_phase, n_phase;

    logic [SB-1:0]        r_cx, r_cz;
    logic [FRAC_BITS-1:0] r_fx, r_fz;
    logic                 r_upper, r_off;

    logic [CELL_W-1:0]    ld_x, ld_z;
    logic [CHAN_W-1:0]    ld_r, ld_g, ld_b;
    logic                 ld_in_range;
    logic [POS_W-1:0]     pos_x, pos_z;
    logic [POS_W-1:0]     cx_full, cz_full, w_eff, d_eff;
    logic                 live_off, live_upper;
    logic [FRAC_BITS-1:0] live_fx, live_fz;
    logic [FRAC_BITS:0]   live_fsum;

    logic [SB-1:0]        cur_cx, cur_cz, cx1, cz1;
    logic [FRAC_BITS-1:0] cur_fx, cur_fz;
    logic [FRAC_BITS:0]   cur_fsum, wgt;
    logic                 cur_upper, cur_off;
    logic [ADDR_W-1:0]    rd_addr;

    logic accept, acc_query, acc_load;

    assign ld_x  = i_data[CELL_X_LSB +: CELL_W];
    assign ld_z  = i_data[CELL_Z_LSB +: CELL_W];
    assign ld_r  = i_data[RED_LSB    +: CHAN_W];
    assign ld_g  = i_data[GREEN_LSB  +: CHAN_W];
    assign ld_b  = i_data[BLUE_LSB   +: CHAN_W];
    assign pos_x = i_data[POS_X_LSB  +: POS_W];
    assign pos_z = i_data[POS_Z_LSB  +: POS_W];

    assign ld_in_range = (int'(ld_x) < MAX_SIDE) && (int'(ld_z) < MAX_SIDE);

    // live query decode, used in the accept cycle
    always_comb begin
        cx_full    = POS_W'(pos_x[POS_W-2:0] >> FRAC_BITS);
        cz_full    = POS_W'(pos_z[POS_W-2:0] >> FRAC_BITS);
        w_eff      = (POS_W'(i_grid_width) > SIDE_LIM) ? SIDE_LIM : POS_W'(i_grid_width);
        d_eff      = (POS_W'(i_grid_depth) > SIDE_LIM) ? SIDE_LIM : POS_W'(i_grid_depth);
        live_off   = pos_x[POS_W-1] | pos_z[POS_W-1]
                   | ((cx_full + POS_W'(1)) >= w_eff)
                   | ((cz_full + POS_W'(1)) >= d_eff);
        live_fx    = pos_x[FRAC_BITS-1:0];
        live_fz    = pos_z[FRAC_BITS-1:0];
        live_fsum  = {1'b0, live_fx} + {1'b0, live_fz};
        live_upper = live_fsum > ONE;
    end

    assign o_ready   = (r_phase == PH_IDLE) && i_room;
    assign accept    = i_valid && o_ready;
    assign acc_query = accept && (t_cmd'(i_user) == CMD_QUERY);
    assign acc_load  = accept && (t_cmd'(i_user) == CMD_LOAD);
    assign o_reserve = acc_query;

    // corner order: c10, c01, then c00 (lower) or c11 (upper)
    always_comb begin
        if (r_phase == PH_IDLE) begin
            cur_cx    = SB'(cx_full);
            cur_cz    = SB'(cz_full);
            cur_fx    = live_fx;
            cur_fz    = live_fz;
            cur_upper = live_upper;
            cur_off   = live_off;
        end else begin
            cur_cx    = r_cx;
            cur_cz    = r_cz;
            cur_fx    = r_fx;
            cur_fz    = r_fz;
            cur_upper = r_upper;
            cur_off   = r_off;
        end
        cur_fsum = {1'b0, cur_fx} + {1'b0, cur_fz};
        cx1      = cur_cx + SB'(1);
        cz1      = cur_cz + SB'(1);

        n_phase = r_phase;
        rd_addr = {cur_cz, cx1};
        wgt     = '0;
        unique case (r_phase)
            PH_IDLE: begin
                rd_addr = {cur_cz, cx1};
                wgt     = cur_upper ? (ONE - {1'b0, cur_fz}) : {1'b0, cur_fx};
                if (acc_query) begin
                    n_phase = PH_READ2;
                end
            end
            PH_READ2: begin
                rd_addr = {cz1, cur_cx};
                wgt     = cur_upper ? (ONE - {1'b0, cur_fx}) : {1'b0, cur_fz};
                n_phase = PH_READ3;
            end
            PH_READ3: begin
                if (cur_upper) begin
                    rd_addr = {cz1, cx1};
                    wgt     = cur_fsum - ONE;
                end else begin
                    rd_addr = {cur_cz, cur_cx};
                    wgt     = ONE - cur_fsum;
                end
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        o_mac.valid  = acc_query || (r_phase != PH_IDLE);
        o_mac.first  = (r_phase == PH_IDLE);
        o_mac.last   = (r_phase == PH_READ3);
        o_mac.off    = cur_off;
        o_mac.weight = WGT_W'(wgt);

        o_mem_en    = (acc_load && ld_in_range) || o_mac.valid;
        o_mem_we    = acc_load;
        o_mem_addr  = acc_load ? {SB'(ld_z), SB'(ld_x)} : rd_addr;
        o_mem_wdata = SUM_W'(ld_r) + SUM_W'(ld_g) + SUM_W'(ld_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_cx    <= SB'(cx_full);
            r_cz    <= SB'(cz_full);
            r_fx    <= live_fx;
            r_fz    <= live_fz;
            r_upper <= live_upper;
            r_off   <= live_off;
        end
    end

endmodule

// File: src/ths_mac.sv
// ths_mac: weighted sum of the three corner sums, then scale by 1/45 in
// fixed point and shift down. Depends on ths_pkg.

module ths_mac import ths_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_mac,
    input  logic [SUM_W-1:0]           i_rdata,
    output logic                       o_push,
    output logic signed [HEIGHT_W-1:0] o_height,
    output logic                       o_off
);

    localparam int ACC_W = SUM_W + FRAC_BITS + 1;
    localparam int NW    = ACC_W + 9;
    // half of 45 * 2^FRAC_BITS, for round to nearest
    localparam logic [NW-1:0] ROUND_C = NW'(45) << (FRAC_BITS - 1);

    t_mac_ctl                r_ctl;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic [SUM_W+WGT_W-1:0]  mul;
    logic                    r_s_valid, r_s_off;
    logic [NW-1:0]           num;
    logic [NQ_W-1:0]         nq;
    logic [PROD_W-1:0]       r_p;
    logic                    r_p_valid, r_p_off;
    logic [Q_W-1:0]          q;

    always_comb begin
        mul   = i_rdata * r_ctl.weight;
        n_acc = (r_ctl.first ? '0 : r_acc) + ACC_W'(mul);
        num   = NW'({r_acc, 8'b0}) + ROUND_C;
        nq    = num[FRAC_BITS +: NQ_W];
        q     = r_p[PROD_W-1:DIV45_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= '0;
            r_s_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_ctl     <= i_mac;
            r_s_valid <= r_ctl.valid && r_ctl.last;
            r_p_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
        r_s_off <= r_ctl.off;
        r_p     <= nq * DIV45_MULT;
        r_p_off <= r_s_off;
    end

    assign o_push   = r_p_valid;
    assign o_off    = r_p_off;
    assign o_height = r_p_off ? OFF_HEIGHT : (signed'(HEIGHT_W'(q)) - SHIFT_DOWN);

endmodule

// File: src/ths_ofifo.sv
// ths_ofifo: four-word result queue with a reservation count, so the
// front end only starts a query that is sure of a slot. Depends on ths_pkg.

module ths_ofifo import ths_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_reserve,
    output logic                       o_room,
    input  logic                       i_push,
    input  logic signed [HEIGHT_W-1:0] i_height,
    input  logic                       i_off,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [HEIGHT_W-1:0] o_height,
    output logic                       o_off
);

    logic signed [HEIGHT_W-1:0] r_height [FIFO_DEPTH];
    logic                       r_off    [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0]      r_count, r_resv;
    logic                       pop;

    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && i_ready;
    assign o_room   = (r_resv < FIFO_CNT_W'(FIFO_DEPTH));
    assign o_height = r_height[r_rd_ptr];
    assign o_off    = r_off[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_resv   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(pop);
            // words in flight plus words queued
            r_resv  <= r_resv + FIFO_CNT_W'(i_reserve) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_height[r_wr_ptr] <= i_height;
            r_off[r_wr_ptr]    <= i_off;
        end
    end

endmodule

// File: src/terrain_height_sampler.sv
// terrain_height_sampler: top level. Grid registers, store, sequencer,
// weighted sum and result queue. Depends on ths_pkg and the ths_* modules.
//
// A load word writes one heightmap cell (r+g+b) into a single-port store.
// A query word needs three corner reads from that same port, so a query
// holds off the input until its last read is issued; loads can follow
// every cycle while the output queue has room. A query result is held in
// a four-word output queue, so the input keeps flowing while fewer than
// four results are pending. Cells read by a query must have been loaded
// before; the store has no clearing pass. The user must write the grid size
// registers only while the block is idle; the block does not enforce it.

module terrain_height_sampler import ths_pkg::*; #(
    parameter int MAX_SIDE  = DEF_MAX_SIDE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [GRID_W-1:0]      i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cell_x, cell_z, red, green, blue, pos_x, pos_z, 6 zero bits
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // height, 5 zero bits
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // off_ground
    output logic                   m_axis_tuser
);

    localparam int SB     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int ADDR_W = 2 * SB;

    logic [GRID_W-1:0]          r_grid_width, r_grid_depth;
    logic                       room, reserve;
    logic                       mem_en, mem_we;
    logic [ADDR_W-1:0]          mem_addr;
    logic [SUM_W-1:0]           mem_wdata, mem_rdata;
    t_mac_ctl                   mac_ctl;
    logic                       push, push_off, q_off;
    logic signed [HEIGHT_W-1:0] push_height, q_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GRID_W'(256);
            r_grid_depth <= GRID_W'(256);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_WIDTH: r_grid_width <= i_cfg_data;
                CFG_GRID_DEPTH: r_grid_depth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ths_seq #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_user       (s_axis_tuser),
        .i_room       (room),
        .i_grid_width (r_grid_width),
        .i_grid_depth (r_grid_depth),
        .o_reserve    (reserve),
        .o_mem_en     (mem_en),
        .o_mem_we     (mem_we),
        .o_mem_addr   (mem_addr),
        .o_mem_wdata  (mem_wdata),
        .o_mac        (mac_ctl)
    );

    ths_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    ths_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mac    (mac_ctl),
        .i_rdata  (mem_rdata),
        .o_push   (push),
        .o_height (push_height),
        .o_off    (push_off)
    );

    ths_ofifo u_ofifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (reserve),
        .o_room    (room),
        .i_push    (push),
        .i_height  (push_height),
        .i_off     (push_off),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_height  (q_height),
        .o_off     (q_off)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - HEIGHT_W)'(0), q_height};
    assign m_axis_tuser = q_off;

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking testbench for terrain_height_sampler. Streams heightmap
// loads and height queries, predicts every query result and checks the output.
// Depends on ths_pkg and the RTL under src/.

module tb_top import ths_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE          = DEF_MAX_SIDE;
    localparam int FB            = DEF_FRAC_BITS;
    localparam int ONE           = 1 << FB;
    localparam int Q8_BIAS       = 4096;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int FIELD_END     = POS_Z_LSB + POS_W;

    typedef struct {
        logic signed [HEIGHT_W-1:0] height;
        logic                       off;
    } t_height_due;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [GRID_W-1:0]      i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // predictor state
    logic [SUM_W-1:0]  cell_sums   [SIDE*SIDE];
    bit                cell_loaded [SIDE*SIDE];
    logic [GRID_W-1:0] grid_cols = 9'd256;
    logic [GRID_W-1:0] grid_rows = 9'd256;
    t_height_due       height_due[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned sent_words    = 0;
    int          error_count   = 0;

    // long receiver hold-off: the test flips the toggle, the receiver counts
    logic rx_hold_tog = 1'b0;
    logic rx_hold_ack = 1'b0;
    int   rx_hold_cnt = 0;

    terrain_height_sampler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned cap_side(input logic [GRID_W-1:0] v);
        return (v > SIDE) ? SIDE : int'(v);
    endfunction

    // range used to aim positions; a grid below 2 is aimed as a span of 2
    function automatic int unsigned pick_span(input logic [GRID_W-1:0] v);
        return (cap_side(v) < 2) ? 2 : cap_side(v);
    endfunction

    function automatic longint unsigned corner_sum(input int unsigned x, input int unsigned z);
        return cell_sums[z*SIDE + x];
    endfunction

    function automatic t_height_due calc_height(input logic signed [POS_W-1:0] px,
                                                input logic signed [POS_W-1:0] pz);
        t_height_due       r;
        int unsigned       cx, cz, fx, fz;
        longint unsigned   wsum, num, den;
        r.height = OFF_HEIGHT;
        r.off    = 1'b1;
        if (px < 0 || pz < 0)
            return r;
        cx = int'(px[POS_W-2:FB]);
        cz = int'(pz[POS_W-2:FB]);
        if (cx + 1 >= cap_side(grid_cols) || cz + 1 >= cap_side(grid_rows))
            return r;
        fx = px[FB-1:0];
        fz = pz[FB-1:0];
        if (fx + fz <= ONE)
            wsum = corner_sum(cx, cz) * (ONE - fx - fz) + corner_sum(cx + 1, cz) * fx
                 + corner_sum(cx, cz + 1) * fz;
        else
            wsum = corner_sum(cx + 1, cz) * (ONE - fz)
                 + corner_sum(cx + 1, cz + 1) * (fx + fz - ONE)
                 + corner_sum(cx, cz + 1) * (ONE - fx);
        // height = round(sum / 45) in Q.8, minus 16.0
        den = 64'd45 << FB;
        num = (wsum << 8) + (den >> 1);
        r.height = HEIGHT_W'(longint'(num / den) - Q8_BIAS);
        r.off    = 1'b0;
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_word();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        r[95:FIELD_END] = '0;
        return r[IN_TDATA_W-1:0];
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return CHAN_W'($urandom);
    endfunction

    task automatic note_mismatch(input string msg);
        error_count++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic check_height(input logic [HEIGHT_W-1:0] got_h, input logic got_off);
        t_height_due want;
        if (height_due.size() == 0) begin
            note_mismatch($sformatf("unexpected result: height %0d off %0b",
                                    $signed(got_h), got_off));
            return;
        end
        want = height_due.pop_front();
        if (got_off !== want.off)
            note_mismatch($sformatf("off_ground %0b, expected %0b", got_off, want.off));
        if (got_h !== want.height)
            note_mismatch($sformatf("height %0d, expected %0d", $signed(got_h), want.height));
    endtask

    // receiver: random stalls, long hold-off on request, result check
    always @(posedge i_clk) begin
        if (rx_hold_tog != rx_hold_ack) begin
            rx_hold_ack   <= rx_hold_tog;
            rx_hold_cnt   <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_cnt != 0) begin
            rx_hold_cnt   <= rx_hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_height(m_axis_tdata[HEIGHT_W-1:0], m_axis_tuser);
    end

    // leaves tvalid high after acceptance; an idle pause in the next send or a wait drops it
    task automatic send_word(input t_cmd cmd, input logic [IN_TDATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sent_words++;
    endtask

    task automatic send_load(input int unsigned x, input int unsigned z,
                             input logic [CHAN_W-1:0] rd, input logic [CHAN_W-1:0] gr,
                             input logic [CHAN_W-1:0] bl);
        logic [IN_TDATA_W-1:0] w;
        w = random_word();
        w[CELL_X_LSB +: CELL_W] = CELL_W'(x);
        w[CELL_Z_LSB +: CELL_W] = CELL_W'(z);
        w[RED_LSB +: CHAN_W]    = rd;
        w[GREEN_LSB +: CHAN_W]  = gr;
        w[BLUE_LSB +: CHAN_W]   = bl;
        send_word(CMD_LOAD, w);
        cell_sums[z*SIDE + x]   = SUM_W'(rd) + SUM_W'(gr) + SUM_W'(bl);
        cell_loaded[z*SIDE + x] = 1'b1;
    endtask

    // every corner a query may touch is loaded before the query goes out
    task automatic send_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        logic [IN_TDATA_W-1:0] w;
        int unsigned           cx, cz;
        if (!px[POS_W-1] && !pz[POS_W-1]) begin
            cx = px[POS_W-2:FB];
            cz = pz[POS_W-2:FB];
            for (int dz = 0; dz < 2; dz++)
                for (int dx = 0; dx < 2; dx++)
                    if (cx + dx < SIDE && cz + dz < SIDE
                            && !cell_loaded[(cz + dz)*SIDE + cx + dx])
                        send_load(cx + dx, cz + dz, rand_chan(), rand_chan(), rand_chan());
        end
        w = random_word();
        w[POS_X_LSB +: POS_W] = px;
        w[POS_Z_LSB +: POS_W] = pz;
        send_word(CMD_QUERY, w);
        height_due.insert(height_due.size(), calc_height(px, pz));
    endtask

    task automatic random_load();
        int unsigned x, z;
        if ($urandom_range(4) == 0) begin
            x = $urandom_range(SIDE - 1);
            z = $urandom_range(SIDE - 1);
        end else begin
            x = $urandom_range(pick_span(grid_cols) - 1);
            z = $urandom_range(pick_span(grid_rows) - 1);
        end
        send_load(x, z, rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic random_query();
        int unsigned pick, cols, rows, fx;
        logic [POS_W-1:0] px, pz;
        cols = pick_span(grid_cols);
        rows = pick_span(grid_rows);
        pick = $urandom_range(99);
        if (pick < 15) begin
            px = POS_W'($urandom);
            pz = POS_W'($urandom);
        end else if (pick < 35) begin
            // on or just past the triangle diagonal
            fx = $urandom_range(ONE - 1, 2);
            px = POS_W'($urandom_range(cols - 2) * ONE + fx);
            pz = POS_W'($urandom_range(rows - 2) * ONE + ONE - fx + $urandom_range(1));
        end else begin
            // inside the grid, plus the last column or row now and then
            px = POS_W'($urandom_range((cols + 1) * ONE - 1 > 65535 ? 65535
                                       : (cols + 1) * ONE - 1));
            pz = POS_W'($urandom_range((rows + 1) * ONE - 1 > 65535 ? 65535
                                       : (rows + 1) * ONE - 1));
        end
        send_query(px, pz);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (height_due.size() != 0);
    endtask

    task automatic set_grid(input int unsigned cols, input int unsigned rows);
        wait_drained();
        // loads give no result and may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_GRID_WIDTH;
        i_cfg_data <= GRID_W'(cols);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GRID_DEPTH;
        i_cfg_data <= GRID_W'(rows);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        grid_cols  = GRID_W'(cols);
        grid_rows  = GRID_W'(rows);
    endtask

    task automatic test_corners_and_triangles();
        send_load(0, 0, 8'd0, 8'd0, 8'd0);
        send_load(1, 0, 8'd255, 8'd255, 8'd255);
        send_load(0, 1, 8'd255, 8'd0, 8'd0);
        send_load(1, 1, 8'd0, 8'd255, 8'd128);
        send_query(17'd0, 17'd0);                 // lowest height
        send_query(17'd256, 17'd0);               // highest height
        send_query(17'd255, 17'd0);
        send_query(17'd128, 17'd128);             // fx+fz exactly 1: lower triangle
        send_query(17'd129, 17'd128);             // just into the upper triangle
        send_query(17'd255, 17'd255);
        send_query(17'h1FFFF, 17'd0);             // negative x
        send_query(17'd0, 17'h10000);             // most negative z
        send_query(17'd65535, 17'd0);             // last column
        send_query(17'd65279, 17'd65279);         // last cell inside the grid
        send_query(17'd0, 17'd65280);             // last row
    endtask

    task automatic test_grid_limits();
        set_grid(0, 256);
        send_query(17'd128, 17'd128);
        set_grid(1, 1);
        send_query(17'd0, 17'd0);
        set_grid(2, 2);
        send_query(17'd128, 17'd128);
        send_query(17'd255, 17'd255);
        send_query(17'd256, 17'd0);
        send_query(17'd0, 17'd256);
        set_grid(511, 300);                       // both act as the full store
        send_query(17'd65279, 17'd65025);
        send_query(17'd65280, 17'd0);
        send_query(17'd0, 17'd65280);
        set_grid(257, 2);
        send_query(17'd65279, 17'd255);
        send_query(17'd100, 17'd256);
    endtask

    // n_words counts every word sent, the loads a query pulls in too
    task automatic test_random_traffic(input int unsigned cols, input int unsigned rows,
                                       input int unsigned n_words);
        int unsigned stop_at;
        set_grid(cols, rows);
        stop_at = sent_words + n_words;
        while (sent_words < stop_at) begin
            if ($urandom_range(99) < 30)
                random_load();
            else
                random_query();
        end
    endtask

    // receiver stops for a long stretch while queries keep coming
    task automatic test_output_stall();
        rx_hold_tog <= ~rx_hold_tog;
        repeat (40) random_query();
    endtask

    // sender waits for the output to empty between bursts
    task automatic test_drain_pause();
        repeat (3) begin
            repeat (8) random_query();
            wait_drained();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 12;
        recv_idle_pct = 56;
        test_corners_and_triangles();
        test_grid_limits();
        test_random_traffic(8, 8, 80);
        test_random_traffic($urandom_range(40, 2), $urandom_range(40, 2), 80);

        send_idle_pct = 56;
        recv_idle_pct = 12;
        test_random_traffic(2, 3, 80);
        test_random_traffic(256, 256, 80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic($urandom_range(256, 2), $urandom_range(256, 2), 80);
        test_random_traffic(16, 5, 80);
        test_output_stall();
        test_drain_pause();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
